// ===== src/lrb_pkg.sv =====
// Package with the shared types, codes and constants of the line receive buffer.
`timescale 1ns / 1ps
`default_nettype none

package lrb_pkg;

    // Function codes of an input transaction.
    typedef enum logic [1:0] {
        FUNC_OFFER = 2'd0,
        FUNC_PUSH  = 2'd1,
        FUNC_TAKE  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_READ   = 2'd1,
        ST_UPDATE = 2'd2
    } state_t;

    // One input transaction.
    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic       last_in_packet;
    } in_item_t;

    // One result transaction.
    typedef struct packed {
        logic       ready_res;
        logic [7:0] byte_out;
        logic       rearm;
        logic       empty_read;
        logic [8:0] lines_waiting;
        logic [8:0] space_free;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic load;
    } lrb_cmd_t;

    localparam logic [7:0] CHAR_LF          = 8'h0A;
    localparam logic [7:0] CHAR_CR          = 8'h0D;
    localparam logic [7:0] CHAR_NUL         = 8'h00;
    localparam logic [8:0] LINE_MAX         = 9'd511;
    localparam logic [8:0] PACKET_ROOM_INIT = 9'd64;

    // A carriage return or a line feed ends a line.
    function automatic logic is_line_end(input logic [7:0] b);
        return (b == CHAR_LF) || (b == CHAR_CR);
    endfunction

endpackage

`default_nettype wire

// ===== src/lrb_ctrl.sv =====
// Controller state machine that sequences one transaction through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module lrb_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output lrb_pkg::lrb_cmd_t      cmd
);

    lrb_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            lrb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lrb_pkg::ST_READ;
                end
            end
            lrb_pkg::ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = lrb_pkg::ST_UPDATE;
            end
            lrb_pkg::ST_UPDATE:
            begin
                // The result register must be free before the state is updated.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = lrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lrb_pkg::ST_IDLE;
            end
        endcase
    end

    // A loaded result stays valid until the receiver takes it.
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/lrb_datapath.sv =====
// Datapath with the byte store, pointers, counters and the result register.
`timescale 1ns / 1ps
`default_nettype none

module lrb_datapath #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lrb_pkg::lrb_cmd_t  cmd,
    input  wire lrb_pkg::in_item_t  in_item,
    input  wire logic               cfg_write,
    input  wire logic [8:0]         cfg_data,
    output lrb_pkg::out_item_t      out_result
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = (FW > 9) ? FW : 9;

    logic [7:0]          mem [BUFFER_DEPTH];
    lrb_pkg::in_item_t   item_reg;
    logic [7:0]          rd_data_reg;
    logic [PW-1:0]       head_reg, head_next;
    logic [PW-1:0]       tail_reg, tail_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [8:0]          line_reg, line_next;
    logic                disc_reg, disc_next;
    logic [8:0]          room_reg;
    lrb_pkg::out_item_t  result_reg, result_next;
    logic                wr_en;
    logic [7:0]          taken;
    logic [CW-1:0]       free_v;
    logic [CW-1:0]       free_out;
    logic [CW-1:0]       room_ext;

    // Free space for a given fill level.
    function automatic logic [CW-1:0] free_of(input logic [FW-1:0] f);
        return CW'(BUFFER_DEPTH) - CW'(f);
    endfunction

    // Circular pointer advance.
    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign room_ext = CW'(room_reg);

    // Next state and result of the captured transaction.
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        fill_next   = fill_reg;
        line_next   = line_reg;
        disc_next   = disc_reg;
        wr_en       = 1'b0;
        taken       = lrb_pkg::CHAR_NUL;
        free_v      = '0;
        result_next = '0;
        unique case (lrb_pkg::func_t'(item_reg.func))
            lrb_pkg::FUNC_OFFER:
            begin
                result_next.ready_res = (free_of(fill_reg) >= room_ext);
            end
            lrb_pkg::FUNC_PUSH:
            begin
                if (item_reg.data_byte != lrb_pkg::CHAR_NUL)
                begin
                    // Store unless discarding or full.
                    if (!disc_reg && (fill_reg != FW'(BUFFER_DEPTH)))
                    begin
                        wr_en     = 1'b1;
                        head_next = ptr_inc(head_reg);
                        fill_next = fill_reg + 1'b1;
                    end
                    if (lrb_pkg::is_line_end(item_reg.data_byte))
                    begin
                        if (disc_reg)
                            disc_next = 1'b0;
                        else if (line_reg != lrb_pkg::LINE_MAX)
                            line_next = line_reg + 1'b1;
                    end
                    else if ((fill_next == FW'(BUFFER_DEPTH)) && (line_reg == '0))
                    begin
                        // Full with no line in it: drop everything.
                        fill_next = '0;
                        head_next = '0;
                        tail_next = '0;
                        disc_next = 1'b1;
                    end
                end
                // End-of-packet check.
                if (item_reg.last_in_packet)
                begin
                    result_next.ready_res = 1'b1;
                    if (free_of(fill_next) < room_ext)
                    begin
                        result_next.ready_res = 1'b0;
                        if (line_next == '0)
                        begin
                            fill_next             = '0;
                            head_next             = '0;
                            tail_next             = '0;
                            disc_next             = 1'b1;
                            result_next.ready_res = 1'b1;
                        end
                    end
                end
            end
            lrb_pkg::FUNC_TAKE:
            begin
                if (fill_reg == '0)
                begin
                    result_next.empty_read = 1'b1;
                end
                else
                begin
                    taken     = rd_data_reg;
                    tail_next = ptr_inc(tail_reg);
                    fill_next = fill_reg - 1'b1;
                end
                free_v = free_of(fill_next);
                if (free_v == room_ext)
                begin
                    result_next.rearm = 1'b1;
                end
                else if ((free_v < room_ext) && (line_reg == '0))
                begin
                    fill_next         = '0;
                    head_next         = '0;
                    tail_next         = '0;
                    disc_next         = 1'b1;
                    result_next.rearm = 1'b1;
                end
                if ((line_reg != '0) && lrb_pkg::is_line_end(taken))
                    line_next = line_reg - 1'b1;
                result_next.byte_out = taken;
            end
            default:
            begin
            end
        endcase
        free_out                  = free_of(fill_next);
        result_next.lines_waiting = line_next;
        result_next.space_free    = free_out[8:0];
    end

    // Control state of the buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
            line_reg <= '0;
            disc_reg <= 1'b0;
            room_reg <= lrb_pkg::PACKET_ROOM_INIT;
        end
        else
        begin
            if (cmd.load)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                fill_reg <= fill_next;
                line_reg <= line_next;
                disc_reg <= disc_next;
            end
            if (cfg_write)
                room_reg <= cfg_data;
        end
    end

    // Payload registers: captured transaction and result.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= in_item;
        if (cmd.load)
            result_reg <= result_next;
    end

    // Byte store: read at the tail, written at the head.
    always_ff @(posedge clk)
    begin
        if (cmd.read)
            rd_data_reg <= mem[tail_reg];
        if (cmd.load && wr_en)
            mem[head_reg] <= item_reg.data_byte;
    end

    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== src/line_receive_buffer_with_discard_top.sv =====
// Top level of the line receive buffer with discard.
//
// Usage: a byte receive FIFO that counts complete lines ended by CR or LF.
// The input channel (in_valid, in_ready, in_item) carries one transaction:
// an offer of a packet, one packet byte, a take of one stored byte, or no operation.
// Each input transaction yields exactly one result transaction on the
// output channel (out_valid, out_ready, out_result).
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes the
// packet room threshold; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. Each accepted
// transaction passes through the registered read of the byte store, then
// the state update that loads the result register. A new transaction is
// accepted only after the controller returns to idle from that update.
// Reset empties the buffer, clears the line count and discard mode and sets
// the packet room to 64; no clearing pass is needed.
// When the receiver stalls, the result register holds its transaction and
// the next input is still accepted; its update waits until the held result
// is taken.
`timescale 1ns / 1ps
`default_nettype none

module line_receive_buffer_with_discard_top #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire lrb_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output lrb_pkg::out_item_t      out_result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [8:0]         cfg_data
);

    lrb_pkg::lrb_cmd_t cmd;

    // Configuration writes are taken at once.
    assign cfg_ready = 1'b1;

    // Controller.
    lrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // Datapath.
    lrb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_item    (in_item),
        .cfg_write  (cfg_valid & cfg_ready),
        .cfg_data   (cfg_data),
        .out_result (out_result)
    );

endmodule

`default_nettype wire

// ===== src/lrb_checker.sv =====
// Port-level checker for the line receive buffer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module lrb_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire lrb_pkg::out_item_t out_result,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_result))
        else $error("result changed while stalled");

    // The block works on one transaction at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

    // An empty take returns a zero byte and no packet flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_result.empty_read |->
            (out_result.byte_out == 8'h00) && !out_result.ready_res)
        else $error("empty take returned data");

    // Configuration writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind line_receive_buffer_with_discard_top lrb_checker u_lrb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);

`default_nettype wire
